>>> sv/chrt_pkg.sv
// Shared types, codes and defaults for the hash ring table.
`default_nettype none
package chrt_pkg;
   localparam int unsigned DefPositionBits = 16;
   localparam int unsigned DefMaxNodes     = 32;
   localparam int unsigned FieldBits       = 16;
   localparam int unsigned KindBits        = 3;
   localparam int unsigned StatusBits      = 3;
   localparam int unsigned CountBits       = 6;

   typedef enum logic [KindBits-1:0] {
      KIND_INSERT = 3'd0,
      KIND_REMOVE = 3'd1,
      KIND_LOCATE = 3'd2,
      KIND_PRED   = 3'd3,
      KIND_SUCC   = 3'd4,
      KIND_CLEAR  = 3'd5,
      KIND_NOP6   = 3'd6,
      KIND_NOP7   = 3'd7
   } kind_type;

   typedef enum logic [StatusBits-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_ABSENT   = 3'd2,
      ST_FULL     = 3'd3,
      ST_REPLACED = 3'd4
   } status_type;
endpackage : chrt_pkg
`default_nettype wire

>>> sv/chrt_engine.sv
// Sequencer and table memories: scan, shift and look up the sorted ring.
`default_nettype none
module chrt_engine #(
   parameter int unsigned POSITION_BITS = chrt_pkg::DefPositionBits,
   parameter int unsigned MAX_NODES     = chrt_pkg::DefMaxNodes
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [chrt_pkg::KindBits-1:0]     kind,
   input  wire logic [chrt_pkg::FieldBits-1:0]    position,
   input  wire logic [chrt_pkg::FieldBits-1:0]    node_tag,
   output logic                                   busy,
   output logic                                   done,
   output logic [chrt_pkg::FieldBits-1:0]         found_position,
   output logic [chrt_pkg::FieldBits-1:0]         found_tag,
   output logic [chrt_pkg::StatusBits-1:0]        status,
   output logic [chrt_pkg::CountBits-1:0]         node_count
);
   import chrt_pkg::*;

   localparam int unsigned IdxBits = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int unsigned CntBits = $clog2(MAX_NODES + 1);
   localparam int unsigned PB = (POSITION_BITS < FieldBits) ? POSITION_BITS : FieldBits;
   localparam logic [CntBits-1:0] MaxCnt = CntBits'(MAX_NODES);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_WAIT  = 6'b000100,
      S_SHIFT = 6'b001000,
      S_FETCH = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   logic [FieldBits-1:0] pos_mem [MAX_NODES];
   logic [FieldBits-1:0] tag_mem [MAX_NODES];

   state_type            state_ff, state_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic [CntBits-1:0]   scan_ff, scan_in;     // next address issued
   logic [CntBits-1:0]   rix_ff, rix_in;       // address of data now on read port
   logic                 rvalid_ff, rvalid_in;
   logic [CntBits-1:0]   hit_ff, hit_in;       // index of exact match
   logic                 hitv_ff, hitv_in;
   logic [CntBits-1:0]   ge_ff, ge_in;         // first index with entry >= key
   logic                 gev_ff, gev_in;
   logic [CntBits-1:0]   ptr_ff, ptr_in;       // shift pointer
   logic [KindBits-1:0]  kind_ff;
   logic [FieldBits-1:0] key_ff, tagin_ff;
   logic [FieldBits-1:0] fpos_ff, fpos_in, ftag_ff, ftag_in;
   logic [StatusBits-1:0] st_ff, st_in;

   // memory port signals
   logic                 rd_en;
   logic [IdxBits-1:0]   rd_addr;
   logic [FieldBits-1:0] rd_pos, rd_tag;
   logic                 wr_en;
   logic [IdxBits-1:0]   wr_addr;
   logic [FieldBits-1:0] wr_pos, wr_tag;
   logic                 wr_tag_only;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_pos <= pos_mem[rd_addr];
         rd_tag <= tag_mem[rd_addr];
      end
      if (wr_en) begin
         tag_mem[wr_addr] <= wr_tag;
         if (!wr_tag_only) pos_mem[wr_addr] <= wr_pos;
      end
   end

   logic [FieldBits-1:0] key_m;
   assign key_m = position & FieldBits'((64'd1 << PB) - 64'd1);

   always_ff @(posedge clock) begin
      if (start) begin
         kind_ff  <= kind;
         key_ff   <= key_m;
         tagin_ff <= node_tag;
      end
   end

   always_comb begin
      state_in = state_ff;  count_in = count_ff; scan_in = scan_ff;
      rix_in = rix_ff; rvalid_in = 1'b0; hit_in = hit_ff; hitv_in = hitv_ff;
      ge_in = ge_ff; gev_in = gev_ff; ptr_in = ptr_ff;
      fpos_in = fpos_ff; ftag_in = ftag_ff; st_in = st_ff;
      rd_en = 1'b0; rd_addr = '0;
      wr_en = 1'b0; wr_addr = '0; wr_pos = key_ff; wr_tag = tagin_ff; wr_tag_only = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               fpos_in = key_m; ftag_in = node_tag; st_in = ST_OK;
               hitv_in = 1'b0; gev_in = 1'b0; scan_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // compare data returned for the previous address
            if (rvalid_ff) begin
               if (rd_pos == key_ff && !hitv_ff) begin
                  hitv_in = 1'b1; hit_in = rix_ff;
               end
               if (rd_pos >= key_ff && !gev_ff) begin
                  gev_in = 1'b1; ge_in = rix_ff;
               end
            end
            if (kind_ff == KIND_CLEAR || kind_ff == KIND_NOP6 || kind_ff == KIND_NOP7) begin
               if (kind_ff == KIND_CLEAR) count_in = '0;
               state_in = S_DONE;
            end else if (scan_ff < count_ff) begin
               rd_en = 1'b1; rd_addr = scan_ff[IdxBits-1:0];
               rix_in = scan_ff; rvalid_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end else if (!rvalid_ff) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // scan finished: decide
            state_in = S_DONE;
            unique case (kind_ff)
               KIND_INSERT: begin
                  if (hitv_ff) begin
                     wr_en = 1'b1; wr_tag_only = 1'b1;
                     wr_addr = hit_ff[IdxBits-1:0]; st_in = ST_REPLACED;
                  end else if (count_ff >= MaxCnt) begin
                     st_in = ST_FULL;
                  end else begin
                     ptr_in = count_ff;
                     if (!gev_ff) ge_in = count_ff;
                     state_in = S_SHIFT;
                  end
               end
               KIND_REMOVE: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else if (!hitv_ff) st_in = ST_ABSENT;
                  else begin
                     ptr_in = hit_ff;
                     rd_en = 1'b1; rd_addr = hit_ff[IdxBits-1:0];
                     state_in = S_FETCH;
                  end
               end
               KIND_LOCATE: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else begin
                     rd_en = 1'b1;
                     rd_addr = gev_ff ? ge_ff[IdxBits-1:0] : '0;
                     state_in = S_FETCH;
                  end
               end
               KIND_PRED, KIND_SUCC: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else if (!hitv_ff) st_in = ST_ABSENT;
                  else begin
                     rd_en = 1'b1;
                     if (kind_ff == KIND_PRED)
                        rd_addr = (hit_ff == '0) ? IdxBits'(count_ff - 1'b1)
                                                 : IdxBits'(hit_ff - 1'b1);
                     else
                        rd_addr = (hit_ff + 1'b1 >= count_ff) ? '0
                                                              : IdxBits'(hit_ff + 1'b1);
                     state_in = S_FETCH;
                  end
               end
               default: ;
            endcase
         end
         S_FETCH: begin
            if (kind_ff == KIND_REMOVE) begin
               ftag_in = rd_tag;
               ptr_in = hit_ff;
               state_in = S_SHIFT;
            end else begin
               fpos_in = rd_pos; ftag_in = rd_tag; state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            if (kind_ff == KIND_INSERT) begin
               // move entry ptr-1 up to ptr, one read then one write
               if (ptr_ff == ge_ff) begin
                  wr_en = 1'b1; wr_addr = ptr_ff[IdxBits-1:0];
                  count_in = count_ff + 1'b1; state_in = S_DONE;
               end else if (!rvalid_ff) begin
                  rd_en = 1'b1; rd_addr = IdxBits'(ptr_ff - 1'b1); rvalid_in = 1'b1;
               end else begin
                  wr_en = 1'b1; wr_addr = ptr_ff[IdxBits-1:0];
                  wr_pos = rd_pos; wr_tag = rd_tag;
                  ptr_in = ptr_ff - 1'b1;
               end
            end else begin
               // remove: move entry ptr+1 down to ptr
               if (ptr_ff + 1'b1 >= count_ff) begin
                  count_in = count_ff - 1'b1; state_in = S_DONE;
               end else if (!rvalid_ff) begin
                  rd_en = 1'b1; rd_addr = IdxBits'(ptr_ff + 1'b1); rvalid_in = 1'b1;
               end else begin
                  wr_en = 1'b1; wr_addr = ptr_ff[IdxBits-1:0];
                  wr_pos = rd_pos; wr_tag = rd_tag;
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rvalid_ff <= rvalid_in;
      end
      scan_ff <= scan_in; rix_ff <= rix_in; hit_ff <= hit_in; hitv_ff <= hitv_in;
      ge_ff <= ge_in; gev_ff <= gev_in; ptr_ff <= ptr_in;
      fpos_ff <= fpos_in; ftag_ff <= ftag_in; st_ff <= st_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign done           = (state_ff == S_DONE);
   assign found_position = fpos_ff;
   assign found_tag      = ftag_ff;
   assign status         = st_ff;
   assign node_count     = CountBits'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCnt) else $error("entry count beyond table depth");
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state not one-hot");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> state_ff == S_IDLE) else $error("done not followed by idle");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(state_ff) == S_SHIFT || $past(state_ff) == S_SCAN)
      else $error("count changed outside shift or clear");
endmodule : chrt_engine
`default_nettype wire

>>> sv/consistent_hash_ring_table_unit.sv
// Top level of the hash ring table: handshakes around the table engine.
//
//   channel | direction | ports                                        | handshake
//   req     | in        | req_type, req_position, req_node_tag         | req_valid / req_stall
//   rsp     | out       | rsp_found_position, rsp_found_tag,           | rsp_valid / rsp_stall
//           |           | rsp_status, rsp_node_count                   |
//
// A lookup on a non-empty ring scans the position memory, then decides, fetches and finishes.
// Insert and remove also move each displaced entry with one read then one write; the
// longest item is removing the lowest entry of a full ring. Clear and unused kinds
// skip the scan. The table memories have a single registered read port.
// Reset empties the ring at once; table contents stay undefined until written.
// A finished result waits in the output register; hold new items off while it waits
// under stall, so a second result can never overwrite it.
`default_nettype none
module consistent_hash_ring_table_unit #(
   parameter int unsigned POSITION_BITS = chrt_pkg::DefPositionBits,
   parameter int unsigned MAX_NODES     = chrt_pkg::DefMaxNodes
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [chrt_pkg::KindBits-1:0]      req_type,
   input  wire logic [chrt_pkg::FieldBits-1:0]     req_position,
   input  wire logic [chrt_pkg::FieldBits-1:0]     req_node_tag,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [chrt_pkg::FieldBits-1:0]          rsp_found_position,
   output logic [chrt_pkg::FieldBits-1:0]          rsp_found_tag,
   output logic [chrt_pkg::StatusBits-1:0]         rsp_status,
   output logic [chrt_pkg::CountBits-1:0]          rsp_node_count
);
   import chrt_pkg::*;

   logic busy, done, start;
   logic [FieldBits-1:0]  e_pos, e_tag;
   logic [StatusBits-1:0] e_st;
   logic [CountBits-1:0]  e_cnt;
   logic                  valid_ff, valid_in;

   // hold new items off while the engine works or a result is still unclaimed
   assign req_stall = busy || (valid_ff && rsp_stall);
   assign start     = req_valid && !req_stall;

   chrt_engine #(.POSITION_BITS(POSITION_BITS), .MAX_NODES(MAX_NODES)) u_engine (
      .clock, .reset, .start, .kind(req_type), .position(req_position),
      .node_tag(req_node_tag), .busy, .done,
      .found_position(e_pos), .found_tag(e_tag), .status(e_st), .node_count(e_cnt)
   );

   // a result can only finish when the output register is free (start gated above)
   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (done) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (done) begin
         rsp_found_position <= e_pos;
         rsp_found_tag      <= e_tag;
         rsp_status         <= e_st;
         rsp_node_count     <= e_cnt;
      end
   end

   assign rsp_valid = valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> !valid_ff || !$past(rsp_stall) || !$past(valid_ff))
      else $error("result overwritten while waiting");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy) else $error("item accepted while engine busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid) else $error("finished result not presented");
endmodule : consistent_hash_ring_table_unit
`default_nettype wire

>>> tb/consistent_hash_ring_table_unit_tb.sv
// Self-checking testbench for the hash ring table: predicts every result and compares.
`timescale 1ns / 1ps
module consistent_hash_ring_table_unit_tb;
   import chrt_pkg::*;

   localparam int unsigned RingDepth  = DefMaxNodes;
   localparam int unsigned CycleLimit = 600000;

   // one predicted result of the table
   typedef struct packed {
      logic [FieldBits-1:0]  position;
      logic [FieldBits-1:0]  tag;
      logic [StatusBits-1:0] status;
      logic [CountBits-1:0]  count;
   } ring_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KindBits-1:0]  req_type = KIND_NOP6;
   logic [FieldBits-1:0] req_position = '0;
   logic [FieldBits-1:0] req_node_tag = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [FieldBits-1:0]  rsp_found_position;
   logic [FieldBits-1:0]  rsp_found_tag;
   logic [StatusBits-1:0] rsp_status;
   logic [CountBits-1:0]  rsp_node_count;

   // predictor state: sorted positions and their tags
   logic [FieldBits-1:0] ring_pos [RingDepth];
   logic [FieldBits-1:0] ring_tag [RingDepth];
   int unsigned          ring_count = 0;

   ring_answer_type answers_due[$];
   int  fail_count = 0;
   int  cycle_count = 0;

   consistent_hash_ring_table_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_position(req_position), .req_node_tag(req_node_tag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_found_position(rsp_found_position), .rsp_found_tag(rsp_found_tag),
      .rsp_status(rsp_status), .rsp_node_count(rsp_node_count)
   );

   always #10 clock = ~clock;

   // Hold a generous ceiling on the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL consistent_hash_ring_table_unit");
         $finish;
      end
   end

   // Work out the result of one request and advance the ring copy.
   function automatic ring_answer_type ring_apply(kind_type kind, logic [FieldBits-1:0] pos,
                                                  logic [FieldBits-1:0] tag);
      ring_answer_type a;
      int idx;
      int i;
      a.position = pos;
      a.tag      = tag;
      a.status   = ST_OK;
      idx = -1;
      for (i = 0; i < ring_count; i++)
         if (idx < 0 && ring_pos[i] == pos) idx = i;
      case (kind)
         KIND_INSERT: begin
            if (idx >= 0) begin
               ring_tag[idx] = tag;
               a.status = ST_REPLACED;
            end else if (ring_count >= RingDepth) begin
               a.status = ST_FULL;
            end else begin
               i = ring_count;
               while (i > 0 && ring_pos[i-1] > pos) begin
                  ring_pos[i] = ring_pos[i-1];
                  ring_tag[i] = ring_tag[i-1];
                  i--;
               end
               ring_pos[i] = pos;
               ring_tag[i] = tag;
               ring_count++;
            end
         end
         KIND_REMOVE: begin
            if (ring_count == 0) a.status = ST_EMPTY;
            else if (idx < 0) a.status = ST_ABSENT;
            else begin
               a.tag = ring_tag[idx];
               for (i = idx; i + 1 < ring_count; i++) begin
                  ring_pos[i] = ring_pos[i+1];
                  ring_tag[i] = ring_tag[i+1];
               end
               ring_count--;
            end
         end
         KIND_LOCATE: begin
            if (ring_count == 0) a.status = ST_EMPTY;
            else begin
               idx = 0;
               for (i = ring_count - 1; i >= 0; i--)
                  if (ring_pos[i] >= pos) idx = i;
               a.position = ring_pos[idx];
               a.tag      = ring_tag[idx];
            end
         end
         KIND_PRED, KIND_SUCC: begin
            if (ring_count == 0) a.status = ST_EMPTY;
            else if (idx < 0) a.status = ST_ABSENT;
            else begin
               if (kind == KIND_PRED) idx = (idx == 0) ? ring_count - 1 : idx - 1;
               else idx = (idx + 1 >= ring_count) ? 0 : idx + 1;
               a.position = ring_pos[idx];
               a.tag      = ring_tag[idx];
            end
         end
         KIND_CLEAR: ring_count = 0;
         default: ;
      endcase
      a.count = ring_count[CountBits-1:0];
      return a;
   endfunction

   // Send one item after a random gap; drop valid only when a gap follows.
   task automatic send_request(kind_type kind, logic [FieldBits-1:0] pos,
                               logic [FieldBits-1:0] tag);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_position <= pos;
      req_node_tag <= tag;
      do @(posedge clock); while (req_stall);
      answers_due = {answers_due, ring_apply(kind, pos, tag)};
   endtask

   // Stall the result side at random, with runs of no stall.
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         hold = $urandom_range(0, 6);
         if ($urandom_range(0, 2) == 0) hold = 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      ring_answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            $error("result with nothing expected");
            fail_count++;
         end else begin
            e = answers_due.pop_front();
            if (rsp_found_position !== e.position) begin
               $error("found_position exp %0d got %0d", e.position, rsp_found_position);
               fail_count++;
            end
            if (rsp_found_tag !== e.tag) begin
               $error("found_tag exp %0d got %0d", e.tag, rsp_found_tag);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_node_count !== e.count) begin
               $error("node_count exp %0d got %0d", e.count, rsp_node_count);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [FieldBits-1:0] rand_field();
      return FieldBits'($urandom);
   endfunction

   // Empty-ring cases, extremes, wrap and neighbour checks.
   task automatic test_directed();
      send_request(KIND_LOCATE, 16'h1234, 16'hFFFF);
      send_request(KIND_REMOVE, 16'h0000, 16'h0001);
      send_request(KIND_PRED, 16'hFFFF, 16'h0002);
      send_request(KIND_SUCC, 16'h0000, 16'h0003);
      send_request(KIND_INSERT, 16'h8000, 16'hAAAA);
      send_request(KIND_PRED, 16'h8000, 16'h0000);
      send_request(KIND_SUCC, 16'h8000, 16'h0000);
      send_request(KIND_INSERT, 16'hFFFF, 16'h5555);
      send_request(KIND_INSERT, 16'h0000, 16'hFFFF);
      send_request(KIND_INSERT, 16'h8000, 16'h0000);
      send_request(KIND_LOCATE, 16'h8001, 16'h0000);
      send_request(KIND_LOCATE, 16'hFFFF, 16'h0000);
      send_request(KIND_LOCATE, 16'h0000, 16'h0000);
      send_request(KIND_PRED, 16'h0000, 16'h0000);
      send_request(KIND_SUCC, 16'hFFFF, 16'h0000);
      send_request(KIND_SUCC, 16'h1111, 16'h0000);
      send_request(KIND_REMOVE, 16'h2222, 16'h0000);
      send_request(KIND_REMOVE, 16'h8000, 16'h0000);
      send_request(KIND_NOP6, 16'hFFFF, 16'hFFFF);
      send_request(KIND_NOP7, 16'h0000, 16'h0000);
      send_request(KIND_CLEAR, 16'h5A5A, 16'hA5A5);
      send_request(KIND_LOCATE, 16'h0000, 16'h0000);
   endtask

   // Fill the ring to the top, hit the full case, then drain it.
   task automatic test_full_ring();
      int i;
      for (i = 0; i < RingDepth + 2; i++) send_request(KIND_INSERT, rand_field(), rand_field());
      send_request(KIND_INSERT, 16'h7777, 16'h7777);
      while (ring_count < RingDepth) send_request(KIND_INSERT, rand_field(), rand_field());
      send_request(KIND_INSERT, rand_field() | 16'h0001, 16'h1234);
      send_request(KIND_INSERT, ring_pos[RingDepth-1], 16'hBEEF);
      send_request(KIND_PRED, ring_pos[0], 16'h0000);
      send_request(KIND_SUCC, ring_pos[RingDepth-1], 16'h0000);
      while (ring_count > 0)
         send_request(KIND_REMOVE, ring_pos[$urandom_range(0, ring_count - 1)], rand_field());
   endtask

   // Random traffic, mostly aimed at stored positions.
   task automatic test_random(int n_items);
      int i;
      int roll;
      kind_type kind;
      logic [FieldBits-1:0] pos;
      for (i = 0; i < n_items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) kind = KIND_INSERT;
         else if (roll < 52) kind = KIND_REMOVE;
         else if (roll < 70) kind = KIND_LOCATE;
         else if (roll < 82) kind = KIND_PRED;
         else if (roll < 94) kind = KIND_SUCC;
         else if (roll < 96) kind = KIND_CLEAR;
         else kind = kind_type'($urandom_range(6, 7));
         pos = rand_field();
         if (ring_count > 0 && $urandom_range(0, 2) != 0)
            pos = ring_pos[$urandom_range(0, ring_count - 1)];
         if (kind == KIND_INSERT && ring_count >= RingDepth && $urandom_range(0, 1) == 0)
            kind = KIND_REMOVE;
         send_request(kind, pos, rand_field());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_ring();
      test_random(1550);
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0) $display("PASS consistent_hash_ring_table_unit");
      else $display("FAIL consistent_hash_ring_table_unit");
      $finish;
   end
endmodule

>>> sim.f
sv/chrt_pkg.sv
sv/chrt_engine.sv
sv/consistent_hash_ring_table_unit.sv
tb/consistent_hash_ring_table_unit_tb.sv
